/* rtl/core/hba_pkg.sv */
// hba_pkg: shared widths, lane indices, sextant codes and the hue side-band type
// for the HSV brightness pipeline. No dependencies.
package hba_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 14;
  localparam int GAIN_FRAC = 12;
  localparam int DIV_STEPS = 4;  // quotient bits resolved per divider stage

  localparam int NUM_LANES = 3;
  localparam int LANE_VAL  = 0;  // max / 255
  localparam int LANE_SAT  = 1;  // delta / max
  localparam int LANE_HUE  = 2;  // |num| / delta

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  typedef enum logic [2:0] {
    SEXT_R_Y = 3'd0,
    SEXT_Y_G = 3'd1,
    SEXT_G_C = 3'd2,
    SEXT_C_B = 3'd3,
    SEXT_B_M = 3'd4,
    SEXT_M_R = 3'd5
  } sextant_e;

  typedef struct packed {
    sextant_e base;
    logic     neg;
    logic     chroma;  // delta non-zero
  } hue_tag_t;

endpackage

/* rtl/core/hba_div.sv */
// hba_div: three-lane pipelined divider, floor(num * 2^FRAC_BITS / den) for num <= den,
// restoring with DIV_STEPS quotient bits per stage; the value lane divides by the constant
// 255 through a reciprocal multiply in the first stage. Depends on hba_pkg.
module hba_div #(
  parameter int FRAC_BITS = 12
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  input  logic [hba_pkg::NUM_LANES-1:0][hba_pkg::PIX_W-1:0] num_i,
  input  logic [hba_pkg::NUM_LANES-1:0][hba_pkg::PIX_W-1:0] den_i,
  input  hba_pkg::hue_tag_t                           tag_i,
  output logic                                        valid_o,
  output logic [hba_pkg::NUM_LANES-1:0][FRAC_BITS:0]  quo_o,
  output hba_pkg::hue_tag_t                           tag_o
);
  import hba_pkg::*;

  localparam int QW   = FRAC_BITS + 1;
  localparam int NSTG = (QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int RW   = PIX_W + 1;

  // max * 2^F / 255 as max * ceil(2^(F+RS) / 255) >> RS, exact for 8-bit max
  localparam int RS  = 16;
  localparam int RCW = FRAC_BITS + 9;
  localparam int RPW = PIX_W + RCW;
  localparam longint unsigned RECIP =
    ((64'd1 << (FRAC_BITS + RS)) + 64'd254) / 64'd255;

  logic [NUM_LANES-1:0][RW-1:0]    rem_q [NSTG];
  logic [NUM_LANES-1:0][PIX_W-1:0] den_q [NSTG];
  logic [NUM_LANES-1:0][QW-1:0]    quo_q [NSTG];
  hue_tag_t                        tag_q [NSTG];
  logic [NSTG-1:0]                 vld_q;

  for (genvar gs = 0; gs < NSTG; gs++) begin : g_stage
    logic [NUM_LANES-1:0][RW-1:0]    rem_in, rem_d;
    logic [NUM_LANES-1:0][PIX_W-1:0] den_in;
    logic [NUM_LANES-1:0][QW-1:0]    quo_in, quo_d;
    hue_tag_t                        tag_in;
    logic                            vld_in;

    if (gs == 0) begin : g_first
      logic [RPW-1:0] val_prod;

      always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
          rem_in[l] = {1'b0, num_i[l]};
        end
        den_in   = den_i;
        val_prod = RPW'(num_i[LANE_VAL]) * RPW'(RECIP);
        quo_in   = '0;
        quo_in[LANE_VAL] = val_prod[RS +: QW];
        tag_in   = tag_i;
        vld_in   = valid_i;
      end
    end else begin : g_next
      always_comb begin
        rem_in = rem_q[gs-1];
        den_in = den_q[gs-1];
        quo_in = quo_q[gs-1];
        tag_in = tag_q[gs-1];
        vld_in = vld_q[gs-1];
      end
    end

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int l = 0; l < NUM_LANES; l++) begin
        if (l != LANE_VAL) begin
          for (int i = 0; i < DIV_STEPS; i++) begin
            if (gs * DIV_STEPS + i < QW) begin
              if (gs * DIV_STEPS + i != 0) begin
                rem_d[l] = {rem_d[l][RW-2:0], 1'b0};
              end
              if (rem_d[l] >= {1'b0, den_in[l]}) begin
                rem_d[l] = rem_d[l] - {1'b0, den_in[l]};
                quo_d[l] = {quo_d[l][QW-2:0], 1'b1};
              end else begin
                quo_d[l] = {quo_d[l][QW-2:0], 1'b0};
              end
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[gs] <= 1'b0;
      end else begin
        vld_q[gs] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[gs] <= rem_d;
      den_q[gs] <= den_in;
      quo_q[gs] <= quo_d;
      tag_q[gs] <= tag_in;
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign quo_o   = quo_q[NSTG-1];
  assign tag_o   = tag_q[NSTG-1];

endmodule

/* rtl/core/hba_front.sv */
// hba_front: input register stage; finds max, delta and the hue numerator and
// sets up the three divider lanes. Depends on hba_pkg.
module hba_front (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  input  logic [hba_pkg::PIX_W-1:0]                   red_i,
  input  logic [hba_pkg::PIX_W-1:0]                   green_i,
  input  logic [hba_pkg::PIX_W-1:0]                   blue_i,
  output logic                                        valid_o,
  output logic [hba_pkg::NUM_LANES-1:0][hba_pkg::PIX_W-1:0] num_o,
  output logic [hba_pkg::NUM_LANES-1:0][hba_pkg::PIX_W-1:0] den_o,
  output hba_pkg::hue_tag_t                           tag_o
);
  import hba_pkg::*;

  logic [PIX_W-1:0] mx, mn, delta, mag;
  logic [PIX_W:0]   diff;
  sextant_e         base;

  logic                            valid_q;
  logic [NUM_LANES-1:0][PIX_W-1:0] num_q, num_d, den_q, den_d;
  hue_tag_t                        tag_q, tag_d;

  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    mx = (mx > blue_i) ? mx : blue_i;
    mn = (red_i < green_i) ? red_i : green_i;
    mn = (mn < blue_i) ? mn : blue_i;
    delta = mx - mn;

    if (red_i >= mx) begin
      base = SEXT_R_Y;
      diff = {1'b0, green_i} - {1'b0, blue_i};
    end else if (green_i >= mx) begin
      base = SEXT_G_C;
      diff = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      base = SEXT_B_M;
      diff = {1'b0, red_i} - {1'b0, green_i};
    end
    mag = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];

    num_d[LANE_VAL] = mx;
    den_d[LANE_VAL] = PIX_MAX;
    num_d[LANE_SAT] = delta;
    den_d[LANE_SAT] = mx;
    num_d[LANE_HUE] = mag;
    den_d[LANE_HUE] = delta;

    tag_d.base   = base;
    tag_d.neg    = diff[PIX_W];
    tag_d.chroma = (delta != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    tag_q <= tag_d;
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign tag_o   = tag_q;

endmodule

/* rtl/core/hba_back.sv */
// hba_back: hue assembly and gain product, value clamp and s*f terms, p/q/t
// products, sextant select and byte conversion: four stages. Depends on hba_pkg.
module hba_back #(
  parameter int FRAC_BITS = 12
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  logic [hba_pkg::NUM_LANES-1:0][FRAC_BITS:0] quo_i,
  input  hba_pkg::hue_tag_t                          tag_i,
  input  logic signed [hba_pkg::CFG_W-1:0]           bright_i,
  output logic                                       valid_o,
  output logic [hba_pkg::PIX_W-1:0]                  red_o,
  output logic [hba_pkg::PIX_W-1:0]                  green_o,
  output logic [hba_pkg::PIX_W-1:0]                  blue_o
);
  import hba_pkg::*;

  localparam int W  = FRAC_BITS + 1;
  localparam int HW = FRAC_BITS + 4;
  localparam int PW = W + CFG_W;
  localparam int SW = W + 3;
  localparam int MW = 2 * W;
  localparam int BW = W + PIX_W;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [HW-1:0] SIX_ONE = HW'(6 * (1 << FRAC_BITS));

  // stage B
  logic signed [HW-1:0] hue_base, hue_mag, hue_sum, hue_wrap;
  logic [CFG_W-1:0]     gmag;
  logic [W-1:0]         s_b;
  logic                 vld_b_q;
  logic [W-1:0]         v_b_q, s_b_q;
  logic [PW-1:0]        prod_b_q;
  logic                 bneg_b_q, chroma_b_q;
  sextant_e             sext_b_q;
  logic [FRAC_BITS-1:0] ff_b_q;

  // stage C
  logic [W+1:0]         step_c;
  logic signed [SW-1:0] vsum_c;
  logic [W-1:0]         vp_c_d, ffc_c;
  logic [MW-1:0]        sf_prod, sg_prod;
  logic                 vld_c_q, chroma_c_q;
  logic [W-1:0]         vp_c_q, s_c_q, sf_c_q, sg_c_q;
  sextant_e             sext_c_q;

  // stage D
  logic [MW-1:0]        p_prod, q_prod, t_prod;
  logic                 vld_d_q, chroma_d_q;
  logic [W-1:0]         v_d_q, p_d_q, q_d_q, t_d_q;
  sextant_e             sext_d_q;

  // stage E
  logic [W-1:0]         ro, go, bo;
  logic [BW-1:0]        rb, gb, bb;
  logic                 vld_e_q;
  logic [PIX_W-1:0]     red_q, green_q, blue_q;

  always_comb begin
    s_b      = tag_i.chroma ? quo_i[LANE_SAT] : '0;
    hue_base = signed'(HW'({tag_i.base, {FRAC_BITS{1'b0}}}));
    hue_mag  = signed'(HW'(quo_i[LANE_HUE]));
    hue_sum  = tag_i.neg ? hue_base - hue_mag : hue_base + hue_mag;
    hue_wrap = (hue_sum < 0) ? hue_sum + SIX_ONE : hue_sum;
    if (!tag_i.chroma) begin
      hue_wrap = '0;
    end
    gmag = bright_i[CFG_W-1] ? CFG_W'(-bright_i) : CFG_W'(bright_i);
  end

  always_comb begin
    step_c = prod_b_q[PW-1:GAIN_FRAC];
    vsum_c = bneg_b_q ? signed'(SW'(v_b_q)) - signed'(SW'(step_c))
                      : signed'(SW'(v_b_q)) + signed'(SW'(step_c));
    if (vsum_c < 0) begin
      vp_c_d = '0;
    end else if (vsum_c > signed'(SW'(ONE))) begin
      vp_c_d = ONE;
    end else begin
      vp_c_d = vsum_c[W-1:0];
    end
    ffc_c   = ONE - {1'b0, ff_b_q};
    sf_prod = MW'(s_b_q) * MW'(ff_b_q);
    sg_prod = MW'(s_b_q) * MW'(ffc_c);
  end

  always_comb begin
    p_prod = MW'(vp_c_q) * MW'(ONE - s_c_q);
    q_prod = MW'(vp_c_q) * MW'(ONE - sf_c_q);
    t_prod = MW'(vp_c_q) * MW'(ONE - sg_c_q);
  end

  always_comb begin
    if (!chroma_d_q) begin
      ro = v_d_q; go = v_d_q; bo = v_d_q;
    end else begin
      case (sext_d_q)
        SEXT_R_Y: begin ro = v_d_q; go = t_d_q; bo = p_d_q; end
        SEXT_Y_G: begin ro = q_d_q; go = v_d_q; bo = p_d_q; end
        SEXT_G_C: begin ro = p_d_q; go = v_d_q; bo = t_d_q; end
        SEXT_C_B: begin ro = p_d_q; go = q_d_q; bo = v_d_q; end
        SEXT_B_M: begin ro = t_d_q; go = p_d_q; bo = v_d_q; end
        default:  begin ro = v_d_q; go = p_d_q; bo = q_d_q; end
      endcase
    end
    // x * 255 as shift and subtract
    rb = {ro, {PIX_W{1'b0}}} - BW'(ro);
    gb = {go, {PIX_W{1'b0}}} - BW'(go);
    bb = {bo, {PIX_W{1'b0}}} - BW'(bo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
    end else begin
      vld_b_q <= valid_i;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
      vld_e_q <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    v_b_q      <= quo_i[LANE_VAL];
    s_b_q      <= s_b;
    prod_b_q   <= PW'(quo_i[LANE_VAL]) * PW'(gmag);
    bneg_b_q   <= bright_i[CFG_W-1];
    chroma_b_q <= tag_i.chroma;
    sext_b_q   <= sextant_e'(hue_wrap[FRAC_BITS+2:FRAC_BITS]);
    ff_b_q     <= hue_wrap[FRAC_BITS-1:0];

    vp_c_q     <= vp_c_d;
    s_c_q      <= s_b_q;
    sf_c_q     <= sf_prod[2*FRAC_BITS:FRAC_BITS];
    sg_c_q     <= sg_prod[2*FRAC_BITS:FRAC_BITS];
    chroma_c_q <= chroma_b_q;
    sext_c_q   <= sext_b_q;

    v_d_q      <= vp_c_q;
    p_d_q      <= p_prod[2*FRAC_BITS:FRAC_BITS];
    q_d_q      <= q_prod[2*FRAC_BITS:FRAC_BITS];
    t_d_q      <= t_prod[2*FRAC_BITS:FRAC_BITS];
    chroma_d_q <= chroma_c_q;
    sext_d_q   <= sext_c_q;

    red_q      <= rb[FRAC_BITS+PIX_W-1:FRAC_BITS];
    green_q    <= gb[FRAC_BITS+PIX_W-1:FRAC_BITS];
    blue_q     <= bb[FRAC_BITS+PIX_W-1:FRAC_BITS];
  end

  assign valid_o = vld_e_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

/* rtl/core/hsv_brightness_adjust.sv */
// hsv_brightness_adjust: top level of the HSV value-scaling pixel pipeline.
// Instantiates hba_front, hba_div and hba_back; depends on hba_pkg.
//
// Usage:
//   Pixel in: start_i with red_in_i/green_in_i/blue_in_i. A transfer takes
//   place on every edge with start_i high and busy_o low; busy_o stays low,
//   so a pixel may enter on every cycle.
//   Pixel out: done_o is high for exactly one cycle with red_out_o,
//   green_out_o and blue_out_o; there is no back-pressure.
//   Gain: brightness_q12_i (signed Q1.12) is written on cfg_valid_i while
//   cfg_ready_o is high (always). Change it only when the pipe is empty.
// Depth: set by the restoring divider, four quotient bits per stage, plus one input
//   stage and four stages of hue, gain, p/q/t products and byte conversion.
// Throughput: one pixel per cycle, in order.
// Reset: clears the pipeline valid bits and sets the gain to zero; pixels in
//   flight are dropped.
module hsv_brightness_adjust #(
  parameter int FRAC_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [hba_pkg::PIX_W-1:0]         red_in_i,
  input  logic [hba_pkg::PIX_W-1:0]         green_in_i,
  input  logic [hba_pkg::PIX_W-1:0]         blue_in_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic signed [hba_pkg::CFG_W-1:0]  brightness_q12_i,
  output logic                              done_o,
  output logic [hba_pkg::PIX_W-1:0]         red_out_o,
  output logic [hba_pkg::PIX_W-1:0]         green_out_o,
  output logic [hba_pkg::PIX_W-1:0]         blue_out_o
);
  import hba_pkg::*;

  localparam int DIV_STAGES = (FRAC_BITS + DIV_STEPS) / DIV_STEPS;
  localparam int LAT        = DIV_STAGES + 5;

  logic signed [CFG_W-1:0] brightness_q, brightness_d;
  logic                    in_fire;

  logic                            fr_valid;
  logic [NUM_LANES-1:0][PIX_W-1:0] fr_num, fr_den;
  hue_tag_t                        fr_tag;

  logic                            dv_valid;
  logic [NUM_LANES-1:0][FRAC_BITS:0] dv_quo;
  hue_tag_t                        dv_tag;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_fire     = start_i && !busy_o;

  assign brightness_d = (cfg_valid_i && cfg_ready_o) ? brightness_q12_i : brightness_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= '0;
    end else begin
      brightness_q <= brightness_d;
    end
  end

  hba_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_fire),
    .red_i   (red_in_i),
    .green_i (green_in_i),
    .blue_i  (blue_in_i),
    .valid_o (fr_valid),
    .num_o   (fr_num),
    .den_o   (fr_den),
    .tag_o   (fr_tag)
  );

  hba_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .num_i   (fr_num),
    .den_i   (fr_den),
    .tag_i   (fr_tag),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .tag_o   (dv_tag)
  );

  hba_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (dv_valid),
    .quo_i    (dv_quo),
    .tag_i    (dv_tag),
    .bright_i (brightness_q),
    .valid_o  (done_o),
    .red_o    (red_out_o),
    .green_o  (green_out_o),
    .blue_o   (blue_out_o)
  );

`ifndef SYNTH
  a_lat_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ##LAT done_o)
    else $error("pixel transfer without result at fixed latency");

  a_lat_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni, LAT)) |-> $past(in_fire, LAT))
    else $error("result strobe without matching pixel transfer");

  a_gray : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && red_in_i == green_in_i && green_in_i == blue_in_i) |->
      ##LAT (red_out_o == green_out_o && green_out_o == blue_out_o))
    else $error("gray pixel gave unequal channels");

  a_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && red_in_i == '0 && green_in_i == '0 && blue_in_i == '0) |->
      ##LAT (red_out_o == '0 && green_out_o == '0 && blue_out_o == '0))
    else $error("black pixel did not stay black");
`endif

endmodule

/* verif/tb_hsv_brightness_adjust.sv */
// tb_hsv_brightness_adjust: self-checking testbench for the HSV value-scaling pipeline,
// a directed table then random pixels over several gains, checked by an in-bench predictor.
// Depends on hba_pkg and hsv_brightness_adjust.
`timescale 1ns / 100ps

module tb_hsv_brightness_adjust;
  import hba_pkg::*;

  localparam int FRAC = 12;
  localparam longint ONE = longint'(1) << FRAC;
  localparam int RAND_BLOCKS = 12;
  localparam int BLOCK_PIXELS = 100;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] gain;
    rgb_t                    px;
    logic                    known;
    rgb_t                    want;
  } vec_t;

  // known rows carry the result by hand, the rest go through the predictor
  localparam vec_t DIRECTED [24] = '{
    '{14'sd0,      '{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{14'sd0,      '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{14'sd0,      '{8'd255, 8'd0,   8'd0},   1'b1, '{8'd255, 8'd0,   8'd0}},
    '{14'sd0,      '{8'd0,   8'd255, 8'd0},   1'b1, '{8'd0,   8'd255, 8'd0}},
    '{14'sd0,      '{8'd0,   8'd0,   8'd255}, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{14'sd0,      '{8'd255, 8'd255, 8'd0},   1'b1, '{8'd255, 8'd255, 8'd0}},
    '{14'sd0,      '{8'd0,   8'd255, 8'd255}, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{14'sd0,      '{8'd255, 8'd0,   8'd255}, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{14'sd0,      '{8'd128, 8'd128, 8'd128}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{14'sd0,      '{8'd1,   8'd0,   8'd0},   1'b0, '{8'd0,   8'd0,   8'd0}},
    '{14'sd0,      '{8'd254, 8'd1,   8'd128}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{14'sd0,      '{8'd0,   8'd0,   8'd1},   1'b0, '{8'd0,   8'd0,   8'd0}},
    '{14'sd0,      '{8'd255, 8'd254, 8'd0},   1'b0, '{8'd0,   8'd0,   8'd0}},
    '{14'sd4096,   '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{14'sd4096,   '{8'd100, 8'd100, 8'd100}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{14'sd4096,   '{8'd200, 8'd50,  8'd10},  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{-14'sd4096,  '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0,   8'd0,   8'd0}},
    '{-14'sd4096,  '{8'd255, 8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{14'sh1FFF,   '{8'd255, 8'd0,   8'd0},   1'b1, '{8'd255, 8'd0,   8'd0}},
    '{14'sh1FFF,   '{8'd10,  8'd20,  8'd30},  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{14'sh2000,   '{8'd90,  8'd60,  8'd30},  1'b1, '{8'd0,   8'd0,   8'd0}},
    '{14'sh2000,   '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0,   8'd0,   8'd0}},
    '{-14'sd1,     '{8'd255, 8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{-14'sd1,     '{8'd7,   8'd200, 8'd199}, 1'b0, '{8'd0,   8'd0,   8'd0}}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic [PIX_W-1:0]        red_in_i;
  logic [PIX_W-1:0]        green_in_i;
  logic [PIX_W-1:0]        blue_in_i;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic signed [CFG_W-1:0] brightness_q12_i;
  logic                    done_o;
  logic [PIX_W-1:0]        red_out_o;
  logic [PIX_W-1:0]        green_out_o;
  logic [PIX_W-1:0]        blue_out_o;

  rgb_t                    want_px;
  rgb_t                    pixels_due[$];
  logic signed [CFG_W-1:0] gain_now;
  int                      errors;

  hsv_brightness_adjust #(
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .red_in_i        (red_in_i),
    .green_in_i      (green_in_i),
    .blue_in_i       (blue_in_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .brightness_q12_i(brightness_q12_i),
    .done_o          (done_o),
    .red_out_o       (red_out_o),
    .green_out_o     (green_out_o),
    .blue_out_o      (blue_out_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [PIX_W-1:0] to_chan(longint x);
    return PIX_W'((x * 255) >>> FRAC);
  endfunction

  // RGB -> HSV, value times (1 + gain) clamped to 0..1, back to RGB
  function automatic rgb_t adjust_value(rgb_t px, logic signed [CFG_W-1:0] gain);
    longint   r, g, b, mx, mn, delta, v, s, hue, base, num, mag, gl, step;
    longint   ff, sf, sg, p, q, t, ro, go, bo;
    sextant_e sext;
    rgb_t     res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    delta = mx - mn;
    v = (mx * ONE) / 255;
    s = 0;
    hue = 0;
    if (mx > 0) s = (delta * ONE) / mx;
    if (delta > 0) begin
      if (r >= mx) begin
        base = 0;
        num = g - b;
      end else if (g >= mx) begin
        base = 2;
        num = b - r;
      end else begin
        base = 4;
        num = r - g;
      end
      mag = (num < 0) ? -num : num;
      mag = (mag * ONE) / delta;
      hue = base * ONE + ((num < 0) ? -mag : mag);
      if (hue < 0) hue += 6 * ONE;
      if (hue >= 6 * ONE) hue = 0;
    end
    gl = gain;
    mag = (gl < 0) ? -gl : gl;
    step = (v * mag) >>> GAIN_FRAC;
    if (gl < 0) step = -step;
    v += step;
    if (v > ONE) v = ONE;
    if (v < 0) v = 0;
    if (s <= 0) begin
      ro = v;
      go = v;
      bo = v;
    end else begin
      sext = sextant_e'(3'(hue >>> FRAC));
      ff = hue % ONE;
      sf = (s * ff) >>> FRAC;
      sg = (s * (ONE - ff)) >>> FRAC;
      p = (v * (ONE - s)) >>> FRAC;
      q = (v * (ONE - sf)) >>> FRAC;
      t = (v * (ONE - sg)) >>> FRAC;
      case (sext)
        SEXT_R_Y: begin ro = v; go = t; bo = p; end
        SEXT_Y_G: begin ro = q; go = v; bo = p; end
        SEXT_G_C: begin ro = p; go = v; bo = t; end
        SEXT_C_B: begin ro = p; go = q; bo = v; end
        SEXT_B_M: begin ro = t; go = p; bo = v; end
        default:  begin ro = v; go = p; bo = q; end
      endcase
    end
    res.red = to_chan(ro);
    res.green = to_chan(go);
    res.blue = to_chan(bo);
    return res;
  endfunction

  task automatic check_chan(string name, logic [PIX_W-1:0] due, logic [PIX_W-1:0] got);
    if (got !== due) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, due, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    rgb_t due;
    if (rst_ni && done_o) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel %0d %0d %0d", $time, red_out_o, green_out_o,
                 blue_out_o);
        errors++;
      end else begin
        due = pixels_due.pop_front();
        check_chan("red", due.red, red_out_o);
        check_chan("green", due.green, green_out_o);
        check_chan("blue", due.blue, blue_out_o);
      end
    end
    if (rst_ni && start_i && !busy_o) pixels_due.push_back(want_px);
  end

  task automatic send_pixel(rgb_t px, rgb_t want, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    red_in_i <= px.red;
    green_in_i <= px.green;
    blue_in_i <= px.blue;
    want_px <= want;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_gain(logic signed [CFG_W-1:0] gain);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    brightness_q12_i <= gain;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    gain_now = gain;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    rgb_t                    px;
    rgb_t                    want;
    logic signed [CFG_W-1:0] gain;
    logic [PIX_W-1:0]        c, d;
    int                      idle_pct;
    int                      gi;
    errors = 0;
    gain_now = '0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    red_in_i = '0;
    green_in_i = '0;
    blue_in_i = '0;
    cfg_valid_i = 1'b0;
    brightness_q12_i = '0;
    want_px = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (i == 0 || DIRECTED[i].gain != gain_now) begin
        drain();
        set_gain(DIRECTED[i].gain);
      end
      want = DIRECTED[i].known ? DIRECTED[i].want : adjust_value(DIRECTED[i].px, gain_now);
      send_pixel(DIRECTED[i].px, want, 0);
    end

    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      case (blk)
        0: gain = 14'sd0;
        1: gain = 14'sd4096;
        2: gain = -14'sd4096;
        3: gain = 14'sh1FFF;
        4: gain = 14'sh2000;
        RAND_BLOCKS - 1: gain = 14'($urandom);
        default: begin
          gi = int'($urandom_range(8192)) - 4096;
          gain = 14'(gi);
        end
      endcase
      case (blk % 3)
        0: idle_pct = 0;
        1: idle_pct = 63;
        default: idle_pct = 19;
      endcase
      drain();
      set_gain(gain);
      for (int n = 0; n < BLOCK_PIXELS; n++) begin
        c = 8'($urandom);
        d = 8'($urandom);
        case ($urandom_range(7))
          0, 1, 2: px = rgb_t'(24'($urandom));
          3: px = '{c, c, c};
          4: begin
            // two channels tied, so the largest-channel order is exercised
            case ($urandom_range(2))
              0: px = '{d, c, c};
              1: px = '{c, d, c};
              default: px = '{c, c, d};
            endcase
          end
          5: begin
            px.red = ($urandom_range(2) == 0) ? 8'd0 : (($urandom_range(1) == 0) ? 8'd255 : c);
            px.green = ($urandom_range(2) == 0) ? 8'd0 : (($urandom_range(1) == 0) ? 8'd255 : d);
            px.blue = ($urandom_range(2) == 0) ? 8'd0 : 8'd255;
          end
          6: px = '{8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom_range(3))};
          default: px = '{8'(255 - $urandom_range(3)), 8'(255 - $urandom_range(3)),
                          8'(255 - $urandom_range(3))};
        endcase
        send_pixel(px, adjust_value(px, gain_now), idle_pct);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* hsv_brightness_adjust.f */
rtl/core/hba_pkg.sv
rtl/core/hba_div.sv
rtl/core/hba_front.sv
rtl/core/hba_back.sv
rtl/core/hsv_brightness_adjust.sv
verif/tb_hsv_brightness_adjust.sv
